[rtl/scle_pkg.sv]
// Shared types, scancode constants and translation tables for the scancode line editor.
// No dependencies; every other file imports this package.
package scle_pkg;

	localparam int LINE_CAPACITY_DEF = 2048;
	localparam int LEN_MAX           = 4095;
	localparam int LEN_W             = 12;
	localparam int POS_W             = 11;
	localparam int CHAR_W            = 7;
	localparam int KIND_W            = 3;

	localparam logic [7:0] SC_RELEASE_BIT = 8'h80;
	localparam logic [6:0] SC_KEY_MASK    = 7'h7F;
	localparam logic [7:0] SC_ESC         = 8'h01;
	localparam logic [7:0] SC_BACKSPACE   = 8'h0E;
	localparam logic [7:0] SC_ENTER       = 8'h1C;
	localparam logic [7:0] SC_SHIFT_L     = 8'h2A;
	localparam logic [7:0] SC_SHIFT_R     = 8'h36;
	localparam logic [7:0] SC_TABLE_SIZE  = 8'd58;
	localparam logic [6:0] ASCII_ESC      = 7'd27;

	typedef enum logic [KIND_W-1:0] {
		EV_NONE       = 3'd0,
		EV_CHAR       = 3'd1,
		EV_BACKSPACE  = 3'd2,
		EV_LINE_END   = 3'd3,
		EV_MODE_START = 3'd4
	} event_kind_t;

	typedef struct packed {
		logic             shift_held;
		logic             line_mode_on;
		logic [LEN_W-1:0] length_count;
	} edit_state_t;

	typedef struct packed {
		event_kind_t       kind;
		logic [CHAR_W-1:0] character;
		logic [POS_W-1:0]  position;
		logic [LEN_W-1:0]  line_length;
		logic              overflow;
	} edit_event_t;

	function automatic logic [CHAR_W-1:0] lower_map(input logic [5:0] idx);
		logic [CHAR_W-1:0] c;
		unique case (idx)
			6'd1:  c = 7'h1B;  6'd2:  c = 7'h31;  6'd3:  c = 7'h32;  6'd4:  c = 7'h33;
			6'd5:  c = 7'h34;  6'd6:  c = 7'h35;  6'd7:  c = 7'h36;  6'd8:  c = 7'h37;
			6'd9:  c = 7'h38;  6'd10: c = 7'h39;  6'd11: c = 7'h30;  6'd12: c = 7'h2D;
			6'd13: c = 7'h3D;  6'd14: c = 7'h08;  6'd15: c = 7'h09;  6'd16: c = 7'h71;
			6'd17: c = 7'h77;  6'd18: c = 7'h65;  6'd19: c = 7'h72;  6'd20: c = 7'h74;
			6'd21: c = 7'h79;  6'd22: c = 7'h75;  6'd23: c = 7'h69;  6'd24: c = 7'h6F;
			6'd25: c = 7'h70;  6'd26: c = 7'h5B;  6'd27: c = 7'h5D;  6'd28: c = 7'h0A;
			6'd30: c = 7'h61;  6'd31: c = 7'h73;  6'd32: c = 7'h64;  6'd33: c = 7'h66;
			6'd34: c = 7'h67;  6'd35: c = 7'h68;  6'd36: c = 7'h6A;  6'd37: c = 7'h6B;
			6'd38: c = 7'h6C;  6'd39: c = 7'h3B;  6'd40: c = 7'h27;  6'd41: c = 7'h60;
			6'd43: c = 7'h5C;  6'd44: c = 7'h7A;  6'd45: c = 7'h78;  6'd46: c = 7'h63;
			6'd47: c = 7'h76;  6'd48: c = 7'h62;  6'd49: c = 7'h6E;  6'd50: c = 7'h6D;
			6'd51: c = 7'h2C;  6'd52: c = 7'h2E;  6'd53: c = 7'h2F;  6'd55: c = 7'h2A;
			6'd57: c = 7'h20;
			default: c = 7'h00;
		endcase
		return c;
	endfunction

	function automatic logic [CHAR_W-1:0] upper_map(input logic [5:0] idx);
		logic [CHAR_W-1:0] c;
		unique case (idx)
			6'd1:  c = 7'h1B;  6'd2:  c = 7'h21;  6'd3:  c = 7'h40;  6'd4:  c = 7'h23;
			6'd5:  c = 7'h24;  6'd6:  c = 7'h25;  6'd7:  c = 7'h5E;  6'd8:  c = 7'h26;
			6'd9:  c = 7'h2A;  6'd10: c = 7'h28;  6'd11: c = 7'h29;  6'd12: c = 7'h5F;
			6'd13: c = 7'h2B;  6'd14: c = 7'h08;  6'd15: c = 7'h09;  6'd16: c = 7'h51;
			6'd17: c = 7'h57;  6'd18: c = 7'h45;  6'd19: c = 7'h52;  6'd20: c = 7'h54;
			6'd21: c = 7'h59;  6'd22: c = 7'h55;  6'd23: c = 7'h49;  6'd24: c = 7'h4F;
			6'd25: c = 7'h50;  6'd26: c = 7'h7B;  6'd27: c = 7'h7D;  6'd28: c = 7'h0A;
			6'd30: c = 7'h41;  6'd31: c = 7'h53;  6'd32: c = 7'h44;  6'd33: c = 7'h46;
			6'd34: c = 7'h47;  6'd35: c = 7'h48;  6'd36: c = 7'h4A;  6'd37: c = 7'h4B;
			6'd38: c = 7'h4C;  6'd39: c = 7'h3A;  6'd40: c = 7'h22;  6'd41: c = 7'h7E;
			6'd43: c = 7'h7C;  6'd44: c = 7'h5A;  6'd45: c = 7'h58;  6'd46: c = 7'h43;
			6'd47: c = 7'h56;  6'd48: c = 7'h42;  6'd49: c = 7'h4E;  6'd50: c = 7'h4D;
			6'd51: c = 7'h3C;  6'd52: c = 7'h3E;  6'd53: c = 7'h3F;  6'd55: c = 7'h2A;
			6'd57: c = 7'h20;
			default: c = 7'h00;
		endcase
		return c;
	endfunction

endpackage

[rtl/scle_step.sv]
// Next-state and event logic for one scancode byte.
// Depends on scle_pkg for the tables, the state and the event types.
module scle_step import scle_pkg::*; #(
	parameter logic [LEN_W-1:0] CAP = LEN_W'(LINE_CAPACITY_DEF)
) (
	input  logic [7:0]  code,
	input  edit_state_t cur,
	output edit_state_t nxt,
	output edit_event_t ev
);

	localparam logic [LEN_W-1:0] CAP_M1 = CAP - LEN_W'(1);

	logic [CHAR_W-1:0] ch;
	logic [LEN_W-1:0]  len_dec;
	logic              is_shift;

	assign is_shift = (code[6:0] == SC_SHIFT_L[6:0]) || (code[6:0] == SC_SHIFT_R[6:0]);
	assign ch       = cur.shift_held ? upper_map(code[5:0]) : lower_map(code[5:0]);
	assign len_dec  = cur.length_count - LEN_W'(1);

	always_comb begin
		nxt            = cur;
		ev.kind        = EV_NONE;
		ev.character   = '0;
		ev.position    = '0;
		ev.overflow    = 1'b0;
		if ((code & SC_RELEASE_BIT) != 8'h00) begin
			if (is_shift)
				nxt.shift_held = 1'b0;
		end else if (is_shift) begin
			nxt.shift_held = 1'b1;
		end else if (code == SC_ESC) begin
			if (!cur.line_mode_on) begin
				nxt.line_mode_on = 1'b1;
				ev.kind          = EV_MODE_START;
			end
		end else if (cur.line_mode_on) begin
			if (code == SC_ENTER) begin
				ev.kind          = EV_LINE_END;
				nxt.length_count = '0;
			end else if (code == SC_BACKSPACE) begin
				if (cur.length_count != '0) begin
					nxt.length_count = len_dec;
					ev.kind          = EV_BACKSPACE;
					ev.position      = len_dec[POS_W-1:0];
				end
			end else if (code < SC_TABLE_SIZE && ch != '0 && ch != ASCII_ESC) begin
				ev.kind      = EV_CHAR;
				ev.character = ch;
				if (cur.length_count < CAP) begin
					ev.position      = cur.length_count[POS_W-1:0];
					nxt.length_count = cur.length_count + LEN_W'(1);
				end else begin
					// full line: hold at capacity and flag it
					ev.position      = CAP_M1[POS_W-1:0];
					ev.overflow      = 1'b1;
					nxt.length_count = CAP;
				end
			end
		end
		// the line end reports the length before the clear
		ev.line_length = (ev.kind == EV_LINE_END) ? cur.length_count : nxt.length_count;
	end

endmodule

[rtl/scancode_line_editor.sv]
// Top level of the scancode line editor: input register, step logic, result register.
// Depends on scle_pkg and scle_step.

// Takes one scancode-set-1 byte per transaction and returns one event per byte, in order.
// A byte passes an input register, is decoded combinationally against the shift, line-mode
// and length state, and lands in the result register; one byte is taken every cycle while
// results are drained. The state is updated when a byte moves into the result register.
// LINE_CAPACITY is clamped to 4095 by the 12-bit length.
module scancode_line_editor import scle_pkg::*; #(
	parameter int LINE_CAPACITY = LINE_CAPACITY_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              scan_valid,
	output logic              scan_stall,
	input  logic [7:0]        scan_byte,
	output logic              event_valid,
	input  logic              event_stall,
	output logic [KIND_W-1:0] event_kind,
	output logic [CHAR_W-1:0] character,
	output logic [POS_W-1:0]  position,
	output logic [LEN_W-1:0]  line_length,
	output logic              overflow
);

	localparam logic [LEN_W-1:0] CAP =
		LEN_W'((LINE_CAPACITY > LEN_MAX) ? LEN_MAX : LINE_CAPACITY);

	logic        valid_s1;
	logic [7:0]  scan_byte_s1;
	logic        valid_s2;
	edit_event_t event_s2;
	edit_state_t state_q;
	edit_state_t state_nxt;
	edit_event_t event_nxt;
	logic        advance;

	assign advance    = !valid_s2 || !event_stall;
	assign scan_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!scan_stall) begin
			valid_s1 <= scan_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!scan_stall && scan_valid)
			scan_byte_s1 <= scan_byte;
	end

	scle_step #(.CAP(CAP)) u_step (
		.code (scan_byte_s1),
		.cur  (state_q),
		.nxt  (state_nxt),
		.ev   (event_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			state_q  <= '0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
			if (valid_s1)
				state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1)
			event_s2 <= event_nxt;
	end

	assign event_valid = valid_s2;
	assign event_kind  = event_s2.kind;
	assign character   = event_s2.character;
	assign position    = event_s2.position;
	assign line_length = event_s2.line_length;
	assign overflow    = event_s2.overflow;

endmodule

[rtl/scle_checker.sv]
// Port-level checks for the scancode line editor, bound to the top level.
// Depends on scle_pkg and scancode_line_editor.
module scle_checker import scle_pkg::*; #(
	parameter int LINE_CAPACITY = LINE_CAPACITY_DEF
) (
	input logic              clk,
	input logic              arst_n,
	input logic              event_valid,
	input logic              event_stall,
	input logic [KIND_W-1:0] event_kind,
	input logic [CHAR_W-1:0] character,
	input logic [POS_W-1:0]  position,
	input logic [LEN_W-1:0]  line_length,
	input logic              overflow
);

	localparam logic [LEN_W-1:0] CAP =
		LEN_W'((LINE_CAPACITY > LEN_MAX) ? LEN_MAX : LINE_CAPACITY);

	// hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		event_valid && event_stall |=> event_valid && $stable(event_kind)
			&& $stable(character) && $stable(position) && $stable(line_length)
			&& $stable(overflow))
		else $error("stalled result changed");

	a_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		event_valid && event_kind != EV_CHAR |-> character == '0 && overflow == 1'b0
			&& (event_kind == EV_BACKSPACE || position == '0))
		else $error("unused fields not zero");

	a_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		event_valid && overflow |-> line_length == CAP)
		else $error("overflow without full line");

	a_bksp: assert property (@(posedge clk) disable iff (!arst_n)
		event_valid && event_kind == EV_BACKSPACE |-> position == line_length[POS_W-1:0]
			&& line_length < CAP)
		else $error("backspace position mismatch");

	a_char: assert property (@(posedge clk) disable iff (!arst_n)
		event_valid && event_kind == EV_CHAR && !overflow |->
			line_length != '0 && position == POS_W'(line_length - LEN_W'(1)))
		else $error("character position mismatch");

endmodule

bind scancode_line_editor scle_checker #(.LINE_CAPACITY(LINE_CAPACITY)) u_scle_checker (.*);
